// ===== hdl/dcf_pkg.sv =====
// Package for the DCF77 time code decoder: field widths, status codes,
// configuration register indexes and frame bit positions.
// No dependencies; every other file of the block imports it.
`default_nettype none

package dcf_pkg;

	// Widths of the channel fields and of the configuration port.
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned CFG_W     = 12;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned MINUTE_W  = 7;
	localparam int unsigned HOUR_W    = 6;
	localparam int unsigned DAY_W     = 6;
	localparam int unsigned MONTH_W   = 5;
	localparam int unsigned YEAR_W    = 8;

	// Decoder status as shown on the result channel.
	typedef enum logic [1:0] {
		ST_WAITING  = 2'd0,
		ST_DECODING = 2'd1,
		ST_DONE     = 2'd2,
		ST_ERROR    = 2'd3
	} status_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_GAP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_HOLD  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_HOLD   = 3'd6;

	// Configuration reset values in milliseconds.
	localparam logic [CFG_W-1:0] RST_ZERO_MIN   = 12'd80;
	localparam logic [CFG_W-1:0] RST_ZERO_MAX   = 12'd120;
	localparam logic [CFG_W-1:0] RST_ONE_MIN    = 12'd180;
	localparam logic [CFG_W-1:0] RST_ONE_MAX    = 12'd220;
	localparam logic [CFG_W-1:0] RST_MINUTE_GAP = 12'd1000;
	localparam logic [CFG_W-1:0] RST_HIGH_HOLD  = 12'd500;
	localparam logic [CFG_W-1:0] RST_LOW_HOLD   = 12'd20;

	// Bit positions inside a minute frame.
	localparam logic [POS_W-1:0] POS_START     = 6'd0;
	localparam logic [POS_W-1:0] POS_TIME_MARK = 6'd20;
	localparam logic [POS_W-1:0] POS_MINUTE    = 6'd21;
	localparam logic [POS_W-1:0] POS_PAR_MIN   = 6'd28;
	localparam logic [POS_W-1:0] POS_HOUR      = 6'd29;
	localparam logic [POS_W-1:0] POS_PAR_HOUR  = 6'd35;
	localparam logic [POS_W-1:0] POS_DAY       = 6'd36;
	localparam logic [POS_W-1:0] POS_WEEKDAY   = 6'd42;
	localparam logic [POS_W-1:0] POS_MONTH     = 6'd45;
	localparam logic [POS_W-1:0] POS_YEAR      = 6'd50;
	localparam logic [POS_W-1:0] POS_LAST      = 6'd58;

endpackage

`default_nettype wire

// ===== hdl/dcf_edge_if.sv =====
// Channel that carries one edge of the demodulated signal: level and timestamp.
// Depends on dcf_pkg for the timestamp width.
`default_nettype none

interface dcf_edge_if
	import dcf_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              level;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output level, output now_ms, input ready);
	modport sink (input valid, input level, input now_ms, output ready);
endinterface

`default_nettype wire

// ===== hdl/dcf_time_if.sv =====
// Channel that carries one decoder result: status, glitch flag, position, BCD fields.
// Depends on dcf_pkg for the field widths.
`default_nettype none

interface dcf_time_if
	import dcf_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic                glitch;
	logic [POS_W-1:0]    bit_position;
	logic [MINUTE_W-1:0] minute_bcd;
	logic [HOUR_W-1:0]   hour_bcd;
	logic [DAY_W-1:0]    day_bcd;
	logic [MONTH_W-1:0]  month_bcd;
	logic [YEAR_W-1:0]   year_bcd;

	modport source (
		output valid, output status, output glitch, output bit_position,
		output minute_bcd, output hour_bcd, output day_bcd, output month_bcd,
		output year_bcd, input ready
	);
	modport sink (
		input valid, input status, input glitch, input bit_position,
		input minute_bcd, input hour_bcd, input day_bcd, input month_bcd,
		input year_bcd, output ready
	);
endinterface

`default_nettype wire

// ===== hdl/dcf77_time_code_decoder.sv =====
// DCF77 time code decoder top level.
// Depends on dcf_pkg, dcf_edge_if and dcf_time_if.
//
// Usage:
// The edges channel takes one edge of the demodulated signal per transfer: the
// new level and the millisecond timestamp of the edge. For every edge the
// result channel delivers exactly one transfer with the decoder status, a
// glitch flag, the next expected bit position and the BCD minute, hour, day,
// month and year registers (also while a frame is only partly decoded).
// Seven 12-bit timing registers are written over the wr_en/wr_index/wr_data
// port; write them only while no edge is in flight.
// Each edge passes through the input register and then the result register.
// Throughput: one edge per cycle unless the receiver stalls; the decoding
// of an edge is a single pass from the input register to the result register.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more edge; only then is edges.ready dropped.
// Reset clears the timing registers to their defaults (80, 120, 180, 220,
// 1000, 500 and 20 ms), drops any frame and sets status to waiting.
`default_nettype none

module dcf77_time_code_decoder
	import dcf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	dcf_edge_if.sink                  edges,
	dcf_time_if.source                result
);

	// Timing registers.
	logic [CFG_W-1:0] zero_min_q, zero_max_q, one_min_q, one_max_q;
	logic [CFG_W-1:0] minute_gap_q, high_hold_q, low_hold_q;

	// Input register.
	logic              valid_s1;
	logic              level_s1;
	logic [TIME_W-1:0] now_s1;

	// Decoder state.
	logic [TIME_W-1:0]   rise_time_q, fall_time_q;
	logic                rise_seen_q, fall_seen_q, frame_q, parity_q;
	logic [POS_W-1:0]    count_q;
	logic [MINUTE_W-1:0] minute_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [DAY_W-1:0]    day_q;
	logic [MONTH_W-1:0]  month_q;
	logic [YEAR_W-1:0]   year_q;
	status_t             status_q;

	// Result register.
	logic                out_valid_q;
	status_t             out_status_q;
	logic                out_glitch_q;
	logic [POS_W-1:0]    out_pos_q;
	logic [MINUTE_W-1:0] out_minute_q;
	logic [HOUR_W-1:0]   out_hour_q;
	logic [DAY_W-1:0]    out_day_q;
	logic [MONTH_W-1:0]  out_month_q;
	logic [YEAR_W-1:0]   out_year_q;

	// Next state.
	logic [TIME_W-1:0]   rise_time_d, fall_time_d;
	logic                rise_seen_d, fall_seen_d, frame_d, parity_d;
	logic [POS_W-1:0]    count_d;
	logic [MINUTE_W-1:0] minute_d;
	logic [HOUR_W-1:0]   hour_d;
	logic [DAY_W-1:0]    day_d;
	logic [MONTH_W-1:0]  month_d;
	logic [YEAR_W-1:0]   year_d;
	status_t             status_d;
	logic                glitch_d;

	// Edge timing and pulse classification.
	logic [TIME_W-1:0] width;
	logic [CFG_W-1:0]  hold;
	logic              width_small;
	logic              is_zero, is_one, bit_val, bit_ok;
	logic [2:0]        ofs_min, ofs_hour, ofs_day, ofs_month, ofs_year;
	logic              advance;

	// The stage moves when the result register is free or being emptied.
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign edges.ready  = !valid_s1 || advance;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_min_q   <= RST_ZERO_MIN;
			zero_max_q   <= RST_ZERO_MAX;
			one_min_q    <= RST_ONE_MIN;
			one_max_q    <= RST_ONE_MAX;
			minute_gap_q <= RST_MINUTE_GAP;
			high_hold_q  <= RST_HIGH_HOLD;
			low_hold_q   <= RST_LOW_HOLD;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ZERO_MIN:   zero_min_q   <= wr_data;
				CFG_ZERO_MAX:   zero_max_q   <= wr_data;
				CFG_ONE_MIN:    one_min_q    <= wr_data;
				CFG_ONE_MAX:    one_max_q    <= wr_data;
				CFG_MINUTE_GAP: minute_gap_q <= wr_data;
				CFG_HIGH_HOLD:  high_hold_q  <= wr_data;
				CFG_LOW_HOLD:   low_hold_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// Input register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (edges.ready) begin
			valid_s1 <= edges.valid;
		end
	end

	// Input register: payload.
	always_ff @(posedge clk) begin
		if (edges.valid && edges.ready) begin
			level_s1 <= edges.level;
			now_s1   <= edges.now_ms;
		end
	end

	// Width since the last accepted edge of the other kind.
	assign width       = now_s1 - (level_s1 ? fall_time_q : rise_time_q);
	assign hold        = level_s1 ? low_hold_q : high_hold_q;
	assign width_small = (width[TIME_W-1:CFG_W] == '0) && (width[CFG_W-1:0] < hold);

	assign is_zero = (width >= {{(TIME_W-CFG_W){1'b0}}, zero_min_q})
		&& (width <= {{(TIME_W-CFG_W){1'b0}}, zero_max_q});
	assign is_one  = (width >= {{(TIME_W-CFG_W){1'b0}}, one_min_q})
		&& (width <= {{(TIME_W-CFG_W){1'b0}}, one_max_q});

	// Offsets of the current bit inside each BCD field.
	assign ofs_min   = 3'(count_q - POS_MINUTE);
	assign ofs_hour  = 3'(count_q - POS_HOUR);
	assign ofs_day   = 3'(count_q - POS_DAY);
	assign ofs_month = 3'(count_q - POS_MONTH);
	assign ofs_year  = 3'(count_q - POS_YEAR);

	// Decode one edge against the current state.
	always_comb begin
		rise_time_d = rise_time_q;
		fall_time_d = fall_time_q;
		rise_seen_d = rise_seen_q;
		fall_seen_d = fall_seen_q;
		frame_d     = frame_q;
		parity_d    = parity_q;
		count_d     = count_q;
		minute_d    = minute_q;
		hour_d      = hour_q;
		day_d       = day_q;
		month_d     = month_q;
		year_d      = year_q;
		status_d    = status_q;
		glitch_d    = 1'b0;
		bit_val     = 1'b0;
		bit_ok      = 1'b1;

		if (level_s1) begin
			// Rising edge: ends a low pulse that carries one bit.
			if (fall_seen_q && width_small) begin
				glitch_d = 1'b1;
			end else begin
				rise_time_d = now_s1;
				rise_seen_d = 1'b1;
				if (frame_q && (count_q <= POS_LAST)) begin
					status_d = ST_DECODING;
					if (is_zero) begin
						bit_val = 1'b0;
					end else if (is_one) begin
						bit_val = 1'b1;
					end else begin
						bit_ok = 1'b0;
					end
					if (bit_ok) begin
						// Bit checks, parity and field fill.
						if (count_q == POS_START) begin
							bit_ok = !bit_val;
						end else if (count_q < POS_TIME_MARK) begin
							bit_ok = 1'b1;
						end else if (count_q == POS_TIME_MARK) begin
							bit_ok = bit_val;
						end else if ((count_q == POS_PAR_MIN) || (count_q == POS_PAR_HOUR)
							|| (count_q == POS_LAST)) begin
							bit_ok = !(parity_q ^ bit_val);
						end else begin
							if ((count_q == POS_MINUTE) || (count_q == POS_HOUR)
								|| (count_q == POS_DAY)) begin
								parity_d = bit_val;
							end else begin
								parity_d = parity_q ^ bit_val;
							end
							if (count_q < POS_HOUR) begin
								minute_d[ofs_min] = bit_val;
							end else if (count_q < POS_DAY) begin
								hour_d[ofs_hour] = bit_val;
							end else if (count_q < POS_WEEKDAY) begin
								day_d[ofs_day] = bit_val;
							end else if (count_q < POS_MONTH) begin
								// Day of week only counts toward the date parity.
							end else if (count_q < POS_YEAR) begin
								month_d[ofs_month] = bit_val;
							end else begin
								year_d[ofs_year] = bit_val;
							end
						end
					end
					if (!bit_ok) begin
						frame_d  = 1'b0;
						count_d  = '0;
						status_d = ST_ERROR;
					end else if (count_q == POS_LAST) begin
						frame_d  = 1'b0;
						count_d  = '0;
						status_d = ST_DONE;
					end else begin
						count_d = count_q + POS_W'(1);
					end
				end else if (frame_q) begin
					frame_d  = 1'b0;
					count_d  = '0;
					status_d = ST_DONE;
				end
			end
		end else begin
			// Falling edge: a long high time marks the minute.
			if (rise_seen_q && width_small) begin
				glitch_d = 1'b1;
			end else begin
				fall_time_d = now_s1;
				fall_seen_d = 1'b1;
				if ((width[TIME_W-1:CFG_W] != '0) || (width[CFG_W-1:0] > minute_gap_q)) begin
					frame_d  = 1'b1;
					count_d  = '0;
					parity_d = 1'b0;
				end else if (!frame_q) begin
					status_d = ST_WAITING;
				end
			end
		end
	end

	// Decoder state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_time_q <= '0;
			fall_time_q <= '0;
			rise_seen_q <= 1'b0;
			fall_seen_q <= 1'b0;
			frame_q     <= 1'b0;
			parity_q    <= 1'b0;
			count_q     <= '0;
			minute_q    <= '0;
			hour_q      <= '0;
			day_q       <= '0;
			month_q     <= '0;
			year_q      <= '0;
			status_q    <= ST_WAITING;
		end else if (advance) begin
			rise_time_q <= rise_time_d;
			fall_time_q <= fall_time_d;
			rise_seen_q <= rise_seen_d;
			fall_seen_q <= fall_seen_d;
			frame_q     <= frame_d;
			parity_q    <= parity_d;
			count_q     <= count_d;
			minute_q    <= minute_d;
			hour_q      <= hour_d;
			day_q       <= day_d;
			month_q     <= month_d;
			year_q      <= year_d;
			status_q    <= status_d;
		end
	end

	// Result register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_status_q <= status_d;
			out_glitch_q <= glitch_d;
			out_pos_q    <= count_d;
			out_minute_q <= minute_d;
			out_hour_q   <= hour_d;
			out_day_q    <= day_d;
			out_month_q  <= month_d;
			out_year_q   <= year_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = out_status_q;
	assign result.glitch       = out_glitch_q;
	assign result.bit_position = out_pos_q;
	assign result.minute_bcd   = out_minute_q;
	assign result.hour_bcd     = out_hour_q;
	assign result.day_bcd      = out_day_q;
	assign result.month_bcd    = out_month_q;
	assign result.year_bcd     = out_year_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for dcf77_time_code_decoder: drives edges with timestamps, and predicts and checks
// every result transfer, including full minute frames and noise under several timing setups.
// Depends on dcf_pkg, dcf_edge_if, dcf_time_if and the decoder RTL.
`timescale 1ns / 1ps

module testbench
	import dcf_pkg::*;
;

	// One expected or observed result transfer.
	typedef struct packed {
		status_t               status;
		logic                  glitch;
		logic [POS_W-1:0]      pos;
		logic [MINUTE_W-1:0]   minute;
		logic [HOUR_W-1:0]     hour;
		logic [DAY_W-1:0]      day;
		logic [MONTH_W-1:0]    month;
		logic [YEAR_W-1:0]     year;
	} time_reading_t;

	// One row of the directed table; pinned rows carry a hand-written expectation.
	typedef struct packed {
		logic              level;
		logic [TIME_W-1:0] now;
		logic              pinned;
		status_t           status;
		logic              glitch;
		logic [POS_W-1:0]  pos;
	} edge_row_t;

	typedef enum {
		FAULT_NONE, FAULT_PARITY, FAULT_START_BIT, FAULT_TIME_MARK,
		FAULT_WIDTH, FAULT_GLITCH, FAULT_EARLY_MARK
	} frame_fault_t;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_EDGES = 550;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	dcf_edge_if edge_ch ();
	dcf_time_if reading_ch ();

	dcf77_time_code_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.edges    (edge_ch),
		.result   (reading_ch)
	);

	// Predictor copy of the timing registers.
	logic [CFG_W-1:0] cfg_zero_min   = RST_ZERO_MIN;
	logic [CFG_W-1:0] cfg_zero_max   = RST_ZERO_MAX;
	logic [CFG_W-1:0] cfg_one_min    = RST_ONE_MIN;
	logic [CFG_W-1:0] cfg_one_max    = RST_ONE_MAX;
	logic [CFG_W-1:0] cfg_minute_gap = RST_MINUTE_GAP;
	logic [CFG_W-1:0] cfg_high_hold  = RST_HIGH_HOLD;
	logic [CFG_W-1:0] cfg_low_hold   = RST_LOW_HOLD;

	// Predictor copy of the decoder state.
	logic [TIME_W-1:0]   edge_rise_ms = '0;
	logic [TIME_W-1:0]   edge_fall_ms = '0;
	logic                rise_taken   = 1'b0;
	logic                fall_taken   = 1'b0;
	logic                in_frame     = 1'b0;
	logic [POS_W-1:0]    next_bit     = '0;
	logic                field_parity = 1'b0;
	logic [MINUTE_W-1:0] minute_r     = '0;
	logic [HOUR_W-1:0]   hour_r       = '0;
	logic [DAY_W-1:0]    day_r        = '0;
	logic [MONTH_W-1:0]  month_r      = '0;
	logic [YEAR_W-1:0]   year_r       = '0;
	status_t             frame_status = ST_WAITING;

	time_reading_t     expected_readings[$];
	logic [TIME_W-1:0] clock_ms = '0;
	bit                calm = 1'b0;
	int                edges_sent = 0;
	int                readings_seen = 0;
	int                mismatches = 0;
	int                quiet_cycles = 0;

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Frame is abandoned, leaving the given status behind.
	function automatic void drop_frame(input status_t st);
		in_frame = 1'b0;
		next_bit = '0;
		frame_status = st;
	endfunction

	// Checks one frame bit and stores it in its field; returns 0 if the check fails.
	function automatic bit accept_frame_bit(input logic [POS_W-1:0] p, input logic b);
		if (p == POS_START) return b == 1'b0;
		if (p < POS_TIME_MARK) return 1'b1;
		if (p == POS_TIME_MARK) return b == 1'b1;
		if (p == POS_MINUTE || p == POS_HOUR || p == POS_DAY) begin
			field_parity = b;
		end else if (p == POS_PAR_MIN || p == POS_PAR_HOUR || p == POS_LAST) begin
			return (field_parity ^ b) == 1'b0;
		end else begin
			field_parity = field_parity ^ b;
		end
		if (p < POS_PAR_MIN) begin
			minute_r[p - POS_MINUTE] = b;
		end else if (p < POS_PAR_HOUR) begin
			hour_r[p - POS_HOUR] = b;
		end else if (p < POS_WEEKDAY) begin
			day_r[p - POS_DAY] = b;
		end else if (p < POS_MONTH) begin
			// Day of week only feeds the date parity.
		end else if (p < POS_YEAR) begin
			month_r[p - POS_MONTH] = b;
		end else begin
			year_r[p - POS_YEAR] = b;
		end
		return 1'b1;
	endfunction

	// Advances the predicted decoder by one edge and returns the result it shows.
	function automatic time_reading_t decode_edge(input logic lvl, input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] span;
		logic              b;
		bit                ok;
		logic              glitch;
		time_reading_t     r;
		glitch = 1'b0;
		if (lvl) begin
			span = t - edge_fall_ms;
			if (fall_taken && span < cfg_low_hold) begin
				glitch = 1'b1;
			end else begin
				edge_rise_ms = t;
				rise_taken = 1'b1;
				if (in_frame && next_bit <= POS_LAST) begin
					frame_status = ST_DECODING;
					ok = 1'b1;
					b = 1'b0;
					if (span >= cfg_zero_min && span <= cfg_zero_max) begin
						b = 1'b0;
					end else if (span >= cfg_one_min && span <= cfg_one_max) begin
						b = 1'b1;
					end else begin
						ok = 1'b0;
					end
					if (ok) ok = accept_frame_bit(next_bit, b);
					if (!ok) drop_frame(ST_ERROR);
					else if (next_bit == POS_LAST) drop_frame(ST_DONE);
					else next_bit = next_bit + 1'b1;
				end else if (in_frame) begin
					drop_frame(ST_DONE);
				end
			end
		end else begin
			span = t - edge_rise_ms;
			if (rise_taken && span < cfg_high_hold) begin
				glitch = 1'b1;
			end else begin
				edge_fall_ms = t;
				fall_taken = 1'b1;
				if (span > cfg_minute_gap) begin
					in_frame = 1'b1;
					next_bit = '0;
					field_parity = 1'b0;
				end else if (!in_frame) begin
					frame_status = ST_WAITING;
				end
			end
		end
		r = '{frame_status, glitch, next_bit, minute_r, hour_r, day_r, month_r, year_r};
		return r;
	endfunction

	// Random value in [lo, hi], or lo when the range is reversed.
	function automatic logic [TIME_W-1:0] pick_in(input logic [CFG_W-1:0] lo,
			input logic [CFG_W-1:0] hi);
		if (lo <= hi) return $urandom_range(hi, lo);
		return lo;
	endfunction

	// Random minute frame with the fixed bits and the three even parities set.
	function automatic logic [POS_LAST:0] build_frame();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		raw[POS_START] = 1'b0;
		raw[POS_TIME_MARK] = 1'b1;
		raw[POS_PAR_MIN] = ^raw[POS_PAR_MIN-1:POS_MINUTE];
		raw[POS_PAR_HOUR] = ^raw[POS_PAR_HOUR-1:POS_HOUR];
		raw[POS_LAST] = ^raw[POS_LAST-1:POS_DAY];
		return raw[POS_LAST:0];
	endfunction

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: result %0d, %s: got %0h, expected %0h",
			$time, readings_seen, field, got, want);
		mismatches++;
	endtask

	task automatic check_reading(input time_reading_t want);
		if (reading_ch.status !== want.status)
			report_mismatch("status", 32'(reading_ch.status), 32'(want.status));
		if (reading_ch.glitch !== want.glitch)
			report_mismatch("glitch", 32'(reading_ch.glitch), 32'(want.glitch));
		if (reading_ch.bit_position !== want.pos)
			report_mismatch("bit_position", 32'(reading_ch.bit_position), 32'(want.pos));
		if (reading_ch.minute_bcd !== want.minute)
			report_mismatch("minute_bcd", 32'(reading_ch.minute_bcd), 32'(want.minute));
		if (reading_ch.hour_bcd !== want.hour)
			report_mismatch("hour_bcd", 32'(reading_ch.hour_bcd), 32'(want.hour));
		if (reading_ch.day_bcd !== want.day)
			report_mismatch("day_bcd", 32'(reading_ch.day_bcd), 32'(want.day));
		if (reading_ch.month_bcd !== want.month)
			report_mismatch("month_bcd", 32'(reading_ch.month_bcd), 32'(want.month));
		if (reading_ch.year_bcd !== want.year)
			report_mismatch("year_bcd", 32'(reading_ch.year_bcd), 32'(want.year));
	endtask

	// Offers one edge, waits for its transfer and records the expected result.
	task automatic send_edge(input logic lvl, input logic [TIME_W-1:0] t, input bit pinned = 1'b0,
			input time_reading_t pinned_reading = '0);
		time_reading_t predicted;
		while (!calm && $urandom_range(0, 99) < 6) begin
			edge_ch.valid <= 1'b0;
			@(negedge clk);
		end
		edge_ch.valid <= 1'b1;
		edge_ch.level <= lvl;
		edge_ch.now_ms <= t;
		do @(posedge clk); while (edge_ch.ready !== 1'b1);
		predicted = decode_edge(lvl, t);
		expected_readings.push_back(pinned ? pinned_reading : predicted);
		clock_ms = t;
		edges_sent++;
		@(negedge clk);
	endtask

	// Stops offering edges and waits until every result has come back.
	task automatic wait_idle();
		edge_ch.valid <= 1'b0;
		while (expected_readings.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// Writes all seven timing registers, one per cycle.
	task automatic load_timing(input logic [CFG_W-1:0] zmin, input logic [CFG_W-1:0] zmax,
			input logic [CFG_W-1:0] omin, input logic [CFG_W-1:0] omax,
			input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] hhold,
			input logic [CFG_W-1:0] lhold);
		logic [CFG_W-1:0]     vals [7];
		logic [CFG_IDX_W-1:0] idx;
		vals[CFG_ZERO_MIN] = zmin;
		vals[CFG_ZERO_MAX] = zmax;
		vals[CFG_ONE_MIN] = omin;
		vals[CFG_ONE_MAX] = omax;
		vals[CFG_MINUTE_GAP] = gap;
		vals[CFG_HIGH_HOLD] = hhold;
		vals[CFG_LOW_HOLD] = lhold;
		for (idx = CFG_ZERO_MIN; idx <= CFG_LOW_HOLD; idx++) begin
			wr_en <= 1'b1;
			wr_index <= idx;
			wr_data <= vals[idx];
			case (idx)
				CFG_ZERO_MIN:   cfg_zero_min = vals[idx];
				CFG_ZERO_MAX:   cfg_zero_max = vals[idx];
				CFG_ONE_MIN:    cfg_one_min = vals[idx];
				CFG_ONE_MAX:    cfg_one_max = vals[idx];
				CFG_MINUTE_GAP: cfg_minute_gap = vals[idx];
				CFG_HIGH_HOLD:  cfg_high_hold = vals[idx];
				default:        cfg_low_hold = vals[idx];
			endcase
			@(negedge clk);
		end
		wr_en <= 1'b0;
	endtask

	// Sends a minute mark and then a whole frame, optionally spoiled by one fault.
	task automatic send_frame(input frame_fault_t fault);
		logic [POS_LAST:0] bits;
		logic [TIME_W-1:0] fell;
		logic [TIME_W-1:0] w;
		int                k;
		int                fault_at;
		bit                restarted;
		bits = build_frame();
		fault_at = $urandom_range(1, POS_LAST);
		restarted = 1'b0;
		case (fault)
			FAULT_PARITY: begin
				case ($urandom_range(0, 2))
					0: bits[POS_PAR_MIN] = ~bits[POS_PAR_MIN];
					1: bits[POS_PAR_HOUR] = ~bits[POS_PAR_HOUR];
					default: bits[POS_LAST] = ~bits[POS_LAST];
				endcase
			end
			FAULT_START_BIT: bits[POS_START] = 1'b1;
			FAULT_TIME_MARK: bits[POS_TIME_MARK] = 1'b0;
			default: ;
		endcase
		// Lead-in rise, then the long high time of the minute mark.
		send_edge(1'b1, clock_ms + cfg_low_hold + 50);
		send_edge(1'b0, clock_ms + cfg_minute_gap + $urandom_range(1, 1500));
		fell = clock_ms;
		k = 0;
		while (k <= POS_LAST) begin
			if (fault == FAULT_GLITCH && k == fault_at && cfg_low_hold != 0)
				send_edge(1'b1, fell + $urandom_range(0, cfg_low_hold - 1));
			w = bits[k] ? pick_in(cfg_one_min, cfg_one_max) : pick_in(cfg_zero_min, cfg_zero_max);
			if (fault == FAULT_WIDTH && k == fault_at) w = cfg_one_max + $urandom_range(1, 200);
			send_edge(1'b1, fell + w);
			if (k < POS_LAST) begin
				if (fault == FAULT_EARLY_MARK && k == fault_at && !restarted) begin
					send_edge(1'b0, clock_ms + cfg_minute_gap + $urandom_range(1, 1500));
					restarted = 1'b1;
					k = 0;
				end else begin
					send_edge(1'b0, clock_ms + pick_in(cfg_high_hold, cfg_minute_gap));
					k++;
				end
				fell = clock_ms;
			end else begin
				k++;
			end
		end
	endtask

	// Random edges with a spread of spacings, from glitches to huge jumps.
	task automatic send_noise(input int n);
		logic [TIME_W-1:0] step;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: step = $urandom_range(0, 40);
				4, 5, 6:    step = $urandom_range(0, 600);
				7, 8:       step = $urandom_range(0, 2500);
				default:    step = $urandom;
			endcase
			send_edge(1'($urandom_range(0, 1)), clock_ms + step);
		end
	endtask

	// Result receiver: stalls now and then, never in a calm phase.
	initial begin
		reading_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			reading_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
		end
	end

	// Result checker and count of cycles without any transfer.
	always @(posedge clk) begin
		if ((edge_ch.valid === 1'b1 && edge_ch.ready === 1'b1) ||
				(reading_ch.valid === 1'b1 && reading_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (arst_n && reading_ch.valid === 1'b1 && reading_ch.ready === 1'b1) begin
			if (expected_readings.size() == 0)
				report_mismatch("transfer with no edge pending", 32'd1, 32'd0);
			else check_reading(expected_readings.pop_front());
			readings_seen++;
		end
	end

	// Watchdog on a stuck handshake.
	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("FAIL dcf77_time_code_decoder");
		$finish;
	end

	// Stimulus: directed table, then phases of frames and noise under varied timing.
	initial begin
		edge_row_t        directed_rows[$];
		edge_row_t        row;
		time_reading_t    pinned_r;
		frame_fault_t     fault;
		logic [CFG_W-1:0] zmin, zmax, omin, omax, gap, hhold;
		int               phase;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		edge_ch.valid = 1'b0;
		edge_ch.level = 1'b0;
		edge_ch.now_ms = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Default timing: holds, minute mark, width edges, errors, wrap, restart mid-frame.
		directed_rows.push_back('{1'b1, 32'd5,          1'b1, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'd10,         1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'd200,        1'b1, ST_WAITING,  1'b1, 6'd0});
		directed_rows.push_back('{1'b0, 32'd1200,       1'b1, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'd1210,       1'b1, ST_WAITING,  1'b1, 6'd0});
		directed_rows.push_back('{1'b1, 32'd1300,       1'b1, ST_DECODING, 1'b0, 6'd1});
		directed_rows.push_back('{1'b0, 32'd2100,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'd2200,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'd3000,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'd3400,       1'b1, ST_ERROR,    1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'd3700,       1'b1, ST_ERROR,    1'b1, 6'd0});
		directed_rows.push_back('{1'b0, 32'd4000,       1'b1, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'd5200,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'd5400,       1'b1, ST_ERROR,    1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'd6401,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'd6481,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'd7481,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'd7601,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'd8101,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'd8281,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'd8781,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'd9001,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'd9501,       1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'd9622,       1'b1, ST_ERROR,    1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'hFFFF_FFF0,  1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b1, 32'h0000_0050,  1'b0, ST_WAITING,  1'b0, 6'd0});
		directed_rows.push_back('{1'b0, 32'd1580,       1'b0, ST_WAITING,  1'b0, 6'd0});
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			pinned_r = '{row.status, row.glitch, row.pos, '0, '0, '0, '0, '0};
			send_edge(row.level, row.now, row.pinned, pinned_r);
		end

		// Random phases; timing is rewritten only once the decoder has drained.
		phase = 0;
		while (edges_sent < directed_rows.size() + RANDOM_EDGES) begin
			wait_idle();
			calm = (phase == 0);
			case (phase % 6)
				1: begin
					load_timing('0, '0, '0, '0, '0, '0, '0);
					send_noise(30);
				end
				2: begin
					load_timing('1, '1, '1, '1, '1, '1, '1);
					send_frame(FAULT_NONE);
					send_noise(10);
				end
				4: begin
					load_timing(CFG_W'($urandom_range(0, 4095)),
						CFG_W'($urandom_range(0, 4095)),
						CFG_W'($urandom_range(0, 4095)),
						CFG_W'($urandom_range(0, 4095)),
						CFG_W'($urandom_range(0, 4095)),
						CFG_W'($urandom_range(0, 4095)),
						CFG_W'($urandom_range(0, 4095)));
					send_noise(40);
				end
				default: begin
					if (phase % 6 == 5) begin
						load_timing(RST_ZERO_MIN, RST_ZERO_MAX, RST_ONE_MIN, RST_ONE_MAX,
							RST_MINUTE_GAP, RST_HIGH_HOLD, RST_LOW_HOLD);
					end else begin
						// Well-ordered ranges so that frames decode.
						zmin = CFG_W'($urandom_range(40, 100));
						zmax = zmin + CFG_W'($urandom_range(0, 60));
						omin = zmax + CFG_W'($urandom_range(10, 80));
						omax = omin + CFG_W'($urandom_range(0, 60));
						hhold = CFG_W'($urandom_range(0, 600));
						gap = hhold + CFG_W'($urandom_range(0, 1000));
						load_timing(zmin, zmax, omin, omax, gap, hhold,
							CFG_W'($urandom_range(0, zmin)));
					end
					// Let the timestamp wrap during this frame.
					if (phase % 6 == 3) clock_ms = '1 - $urandom_range(0, 30000);
					if ($urandom_range(0, 9) < 6) fault = FAULT_NONE;
					else fault = frame_fault_t'($urandom_range(1, 6));
					send_frame(fault);
					send_noise(15);
				end
			endcase
			phase++;
		end

		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("PASS dcf77_time_code_decoder");
		end else begin
			$display("FAIL dcf77_time_code_decoder");
		end
		$finish;
	end

endmodule
